// File: hdl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants for the escape-time iterator
// Fixed-point widths, register indexes, sequencer states and the
// saturation and magnitude helpers used by the top level.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int COORD_BITS = 48;
  localparam int FRAC_BITS  = 44;
  localparam int COUNT_BITS = 16;
  localparam int PIXEL_BITS = 12;
  localparam int STEP_BITS  = COORD_BITS - 1;

  // Operands are split into two halves for the shared multiplier
  localparam int HALF_BITS = (COORD_BITS + 1) / 2;
  localparam int OP_BITS   = 2 * HALF_BITS;
  localparam int MUL_BITS  = 2 * OP_BITS;
  localparam int SUM_BITS  = MUL_BITS + 2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORIGIN_REAL = 3'd0,
    CFG_ORIGIN_IMAG = 3'd1,
    CFG_STEP_REAL   = 3'd2,
    CFG_STEP_IMAG   = 3'd3,
    CFG_ITER_LIMIT  = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_RE,
    ST_C_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CHECK
  } state_t;

  // Reset values: origin (-2.0, -1.5), steps 3/1024 and 1/256
  localparam logic [COORD_BITS-1:0] ORIGIN_REAL_RESET =
    COORD_BITS'(-(64'sd2 <<< FRAC_BITS));
  localparam logic [COORD_BITS-1:0] ORIGIN_IMAG_RESET =
    COORD_BITS'(-(64'sd3 <<< (FRAC_BITS - 1)));
  localparam logic [STEP_BITS-1:0] STEP_REAL_RESET =
    STEP_BITS'(64'd3 << (FRAC_BITS - 10));
  localparam logic [STEP_BITS-1:0] STEP_IMAG_RESET =
    STEP_BITS'(64'd1 << (FRAC_BITS - 8));
  localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(100);

  // Escape threshold 4.0 at double fraction width
  localparam logic [MUL_BITS:0] MAG_LIMIT =
    (MUL_BITS + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Clamp a wide signed sum to the coordinate range
  function automatic logic [COORD_BITS-1:0] saturate(input logic [SUM_BITS-1:0] v);
    logic [SUM_BITS-COORD_BITS:0] upper;
    upper = v[SUM_BITS-1:COORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      return v[COORD_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  // Magnitude of a coordinate as an unsigned multiplier operand
  function automatic logic [OP_BITS-1:0] abs_value(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] m;
    m = v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
    return OP_BITS'(m);
  endfunction

  // Sign-extend a coordinate to the sum width
  function automatic logic [SUM_BITS-1:0] extend(input logic [COORD_BITS-1:0] v);
    return {{(SUM_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

endpackage

// File: hdl/met_mul.sv
// ----------------------------------------------------------------------------
// met_mul: iterative unsigned multiplier
// Forms a full double-width product from four half-by-half partial
// products, one per cycle, registered and then accumulated.
// ----------------------------------------------------------------------------
module met_mul
  import met_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_BITS-1:0]  a,
  input  logic [OP_BITS-1:0]  b,
  output logic                done,
  output logic [MUL_BITS-1:0] product
);

  logic [OP_BITS-1:0]     a_hold;
  logic [OP_BITS-1:0]     b_hold;
  logic [2:0]             step;
  logic                   running;
  logic [HALF_BITS-1:0]   part_a;
  logic [HALF_BITS-1:0]   part_b;
  logic [OP_BITS-1:0]     pp;
  logic [1:0]             pp_shift;
  logic [MUL_BITS-1:0]    pp_aligned;
  logic [MUL_BITS-1:0]    acc;

  // Pick the halves for this step: lo*lo, lo*hi, hi*lo, hi*hi
  assign part_a = step[1] ? a_hold[OP_BITS-1:HALF_BITS] : a_hold[HALF_BITS-1:0];
  assign part_b = step[0] ? b_hold[OP_BITS-1:HALF_BITS] : b_hold[HALF_BITS-1:0];

  // Align the registered partial product
  always_comb begin
    unique case (pp_shift)
      2'd0:    pp_aligned = MUL_BITS'(pp);
      2'd1:    pp_aligned = MUL_BITS'(pp) << HALF_BITS;
      2'd2:    pp_aligned = MUL_BITS'(pp) << (2 * HALF_BITS);
      default: pp_aligned = '0;
    endcase
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == 3'd4) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  // Multiply one partial, accumulate the previous one
  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      b_hold <= b;
      acc    <= '0;
    end else if (running) begin
      pp       <= part_a * part_b;
      pp_shift <= 2'(step[1]) + 2'(step[0]);
      if (step != 3'd0) begin
        acc <= acc + pp_aligned;
      end
    end
  end

  assign product = acc;

endmodule

// File: hdl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: fixed-point escape-time iterator
// Maps a pixel to c, iterates z = z*z + c in Q4.44 and reports the update
// count and whether |z| exceeded 2, using one shared multiplier.
// ----------------------------------------------------------------------------
// Throughput: one pixel at a time, busy high until the result; the shared
//   multiplier (3 products per update, at most iter_limit updates) sets the pace.
// Result is shown for one cycle on result_valid; the receiver cannot stall.
// Reset (rst, synchronous) idles the sequencer and loads the default viewport.
module mandelbrot_escape_time
  import met_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [PIXEL_BITS-1:0]     pixel_x,
  input  logic [PIXEL_BITS-1:0]     pixel_y,
  output logic                      result_valid,
  output logic [COUNT_BITS-1:0]     iteration_count,
  output logic                      escaped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [COORD_BITS-1:0] origin_real;
  logic [COORD_BITS-1:0] origin_imag;
  logic [STEP_BITS-1:0]  step_real;
  logic [STEP_BITS-1:0]  step_imag;
  logic [COUNT_BITS-1:0] iter_limit;

  state_t                state;
  state_t                state_next;
  logic                  finish;
  logic                  finish_escaped;
  logic                  issue;

  logic [PIXEL_BITS-1:0] px;
  logic [PIXEL_BITS-1:0] py;
  logic [COORD_BITS-1:0] c_real;
  logic [COORD_BITS-1:0] c_imag;
  logic [COORD_BITS-1:0] z_real;
  logic [COORD_BITS-1:0] z_imag;
  logic [MUL_BITS-1:0]   zr_sq;
  logic [MUL_BITS-1:0]   zi_sq;
  logic [SUM_BITS-1:0]   diff;
  logic [SUM_BITS-1:0]   cross_prod;
  logic [COUNT_BITS-1:0] update_counter;
  logic [MUL_BITS:0]     mag;
  logic                  beyond;

  logic [OP_BITS-1:0]    mul_a;
  logic [OP_BITS-1:0]    mul_b;
  logic                  mul_done;
  logic [MUL_BITS-1:0]   mul_product;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real <= ORIGIN_REAL_RESET;
      origin_imag <= ORIGIN_IMAG_RESET;
      step_real   <= STEP_REAL_RESET;
      step_imag   <= STEP_IMAG_RESET;
      iter_limit  <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ORIGIN_REAL: origin_real <= cfg_data;
        CFG_ORIGIN_IMAG: origin_imag <= cfg_data;
        CFG_STEP_REAL:   step_real   <= cfg_data[STEP_BITS-1:0];
        CFG_STEP_IMAG:   step_imag   <= cfg_data[STEP_BITS-1:0];
        CFG_ITER_LIMIT:  iter_limit  <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Squared magnitude of the new z against 4.0
  assign mag    = {1'b0, zr_sq} + {1'b0, zi_sq};
  assign beyond = (mag > MAG_LIMIT);

  // Next state and finish flags
  always_comb begin
    state_next     = state;
    finish         = 1'b0;
    finish_escaped = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_C_RE;
      end
      ST_C_RE: begin
        if (mul_done) state_next = ST_C_IM;
      end
      ST_C_IM: begin
        if (mul_done) begin
          if (iter_limit == '0) begin
            state_next = ST_IDLE;
            finish     = 1'b1;
          end else begin
            state_next = ST_CROSS;
          end
        end
      end
      ST_CROSS: begin
        if (mul_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        if (mul_done) state_next = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        if (mul_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (beyond) begin
          state_next     = ST_IDLE;
          finish         = 1'b1;
          finish_escaped = 1'b1;
        end else if (update_counter == iter_limit) begin
          state_next = ST_IDLE;
          finish     = 1'b1;
        end else begin
          state_next = ST_CROSS;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register and multiplier issue on entry to a product state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      issue        <= (state_next != state) &&
                      (state_next == ST_C_RE || state_next == ST_C_IM ||
                       state_next == ST_CROSS || state_next == ST_SQ_RE ||
                       state_next == ST_SQ_IM);
      result_valid <= finish;
    end
  end

  // Select the multiplier operands for the current product
  always_comb begin
    unique case (state)
      ST_C_RE: begin
        mul_a = OP_BITS'(px);
        mul_b = OP_BITS'(step_real);
      end
      ST_C_IM: begin
        mul_a = OP_BITS'(py);
        mul_b = OP_BITS'(step_imag);
      end
      ST_CROSS: begin
        mul_a = abs_value(z_real);
        mul_b = abs_value(z_imag);
      end
      ST_SQ_RE: begin
        mul_a = abs_value(z_real);
        mul_b = abs_value(z_real);
      end
      ST_SQ_IM: begin
        mul_a = abs_value(z_imag);
        mul_b = abs_value(z_imag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  met_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (issue),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (state == ST_C_RE && mul_done) begin
      c_real <= saturate({2'b00, mul_product} + extend(origin_real));
    end
    if (state == ST_C_IM && mul_done) begin
      c_imag         <= saturate({2'b00, mul_product} + extend(origin_imag));
      z_real         <= '0;
      z_imag         <= '0;
      zr_sq          <= '0;
      zi_sq          <= '0;
      diff           <= '0;
      update_counter <= '0;
    end
    // Signed cross product zr*zi
    if (state == ST_CROSS && mul_done) begin
      if (z_real[COORD_BITS-1] ^ z_imag[COORD_BITS-1]) begin
        cross_prod <= -{2'b00, mul_product};
      end else begin
        cross_prod <= {2'b00, mul_product};
      end
    end
    // Advance z by one update
    if (state == ST_UPDATE) begin
      z_real         <= saturate(($signed(diff) >>> FRAC_BITS) + $signed(extend(c_real)));
      z_imag         <= saturate(($signed(cross_prod) >>> (FRAC_BITS - 1)) +
                                 $signed(extend(c_imag)));
      update_counter <= update_counter + COUNT_BITS'(1);
    end
    if (state == ST_SQ_RE && mul_done) begin
      zr_sq <= mul_product;
    end
    if (state == ST_SQ_IM && mul_done) begin
      zi_sq <= mul_product;
    end
    // Difference of squares feeds the next real part
    if (state == ST_CHECK) begin
      diff <= {2'b00, zr_sq} - {2'b00, zi_sq};
    end
    // Hold the result beat
    if (finish) begin
      iteration_count <= (state == ST_CHECK) ? update_counter : '0;
      escaped         <= finish_escaped;
    end
  end

  // An accepted pixel makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a pixel");

  // The result beat is a single-cycle strobe
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // A non-escaped result stopped exactly at the limit
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !escaped) |-> (iteration_count == iter_limit))
    else $error("non-escaped count differs from the limit");

  // Multiplier completions only arrive in product states
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_C_RE || state == ST_C_IM || state == ST_CROSS ||
                  state == ST_SQ_RE || state == ST_SQ_IM))
    else $error("multiplier finished outside a product state");

endmodule
